FILE: hw/rtl/ycq_pkg.sv
package ycq_pkg;

  // Sample and arithmetic widths
  localparam int SAMPLE_W = 8;
  localparam int TERM_W   = 18;
  localparam int SUM_W    = 20;
  localparam int BYTE_W   = 8;
  localparam int PIXEL_W  = 3 * BYTE_W;
  localparam int LANES    = 4;

  // Conversion gains in 8.8 fixed point
  localparam logic signed [SUM_W-1:0]  LUMA_GAIN     = 20'sd298;
  localparam logic signed [SUM_W-1:0]  LUMA_BIAS     = 20'sd112;
  localparam logic signed [TERM_W-1:0] RED_GAIN      = 18'sd409;
  localparam logic signed [TERM_W-1:0] GREEN_CB_GAIN = 18'sd100;
  localparam logic signed [TERM_W-1:0] GREEN_CR_GAIN = 18'sd208;
  localparam logic signed [TERM_W-1:0] BLUE_GAIN     = 18'sd516;

  // Chroma format codes
  localparam logic FMT_411 = 1'b0;
  localparam logic FMT_420 = 1'b1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [TERM_W-1:0]   term_t;
  typedef logic [PIXEL_W-1:0]         pixel_t;

  // Chroma contributions shared by all four pixels
  typedef struct packed {
    term_t red_add;
    term_t green_sub;
    term_t blue_add;
  } chroma_terms_t;

endpackage

FILE: hw/rtl/ycq_chroma_terms.sv
module ycq_chroma_terms (
  input  ycq_pkg::sample_t       chroma_red,
  input  ycq_pkg::sample_t       chroma_blue,
  input  logic                   chroma_format,
  output ycq_pkg::chroma_terms_t terms
);
  import ycq_pkg::*;

  term_t cr_ext;
  term_t cb_ext;
  term_t red_src;
  term_t blue_src;

  assign cr_ext = TERM_W'(chroma_red);
  assign cb_ext = TERM_W'(chroma_blue);

  // Swap the chroma feeding red and blue by format
  assign red_src  = (chroma_format == FMT_411) ? cb_ext : cr_ext;
  assign blue_src = (chroma_format == FMT_411) ? cr_ext : cb_ext;

  // Form the constant products
  assign terms.red_add   = TERM_W'(red_src * RED_GAIN);
  assign terms.green_sub = TERM_W'(cb_ext * GREEN_CB_GAIN + cr_ext * GREEN_CR_GAIN);
  assign terms.blue_add  = TERM_W'(blue_src * BLUE_GAIN);

endmodule

FILE: hw/rtl/ycq_pixel_lane.sv
module ycq_pixel_lane (
  input  ycq_pkg::sample_t       luma,
  input  ycq_pkg::chroma_terms_t terms,
  input  logic                   chroma_format,
  output ycq_pkg::pixel_t        pixel
);
  import ycq_pkg::*;

  logic signed [SUM_W-1:0] y_scaled;
  logic signed [SUM_W-1:0] red_sum;
  logic signed [SUM_W-1:0] green_sum;
  logic signed [SUM_W-1:0] blue_sum;
  logic [BYTE_W-1:0]       red_byte;
  logic [BYTE_W-1:0]       green_byte;
  logic [BYTE_W-1:0]       blue_byte;

  // Clamp a sum to 0..255 after dropping the fraction
  function automatic logic [BYTE_W-1:0] to_byte(input logic signed [SUM_W-1:0] sum);
    logic [BYTE_W-1:0] res;
    if (sum[SUM_W-1]) begin
      res = '0;
    end else if (|sum[SUM_W-2:2*BYTE_W]) begin
      res = '1;
    end else begin
      res = sum[2*BYTE_W-1:BYTE_W];
    end
    return res;
  endfunction

  // Scale luma
  assign y_scaled = SUM_W'((SUM_W'(luma) + LUMA_BIAS) * LUMA_GAIN);

  // Add chroma contributions
  assign red_sum   = y_scaled + SUM_W'(terms.red_add);
  assign green_sum = y_scaled - SUM_W'(terms.green_sub);
  assign blue_sum  = y_scaled + SUM_W'(terms.blue_add);

  assign red_byte   = to_byte(red_sum);
  assign green_byte = to_byte(green_sum);
  assign blue_byte  = to_byte(blue_sum);

  // Pack bytes in memory order, first byte lowest
  assign pixel = (chroma_format == FMT_411) ? {blue_byte, green_byte, red_byte}
                                            : {red_byte, green_byte, blue_byte};

endmodule

FILE: hw/rtl/ycbcr_to_rgb_quad_converter.sv
// Converts one chroma pair and four luma samples to four RGB pixels.
// The start beat is captured in the input registers, and the pixels and done strobe in the result registers.
// Throughput: one group per cycle; busy is tied low.
// The receiver cannot stall: each result shows for one cycle with done high.
// Synchronous reset clears the valid flags and sets chroma_format to 4:1:1.
module ycbcr_to_rgb_quad_converter (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  ycq_pkg::sample_t chroma_red,
  input  ycq_pkg::sample_t chroma_blue,
  input  ycq_pkg::sample_t luma_0,
  input  ycq_pkg::sample_t luma_1,
  input  ycq_pkg::sample_t luma_2,
  input  ycq_pkg::sample_t luma_3,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_data,
  output logic             done,
  output ycq_pkg::pixel_t  pixel_0,
  output ycq_pkg::pixel_t  pixel_1,
  output ycq_pkg::pixel_t  pixel_2,
  output ycq_pkg::pixel_t  pixel_3
);
  import ycq_pkg::*;

  logic          chroma_format;
  logic          in_valid;
  sample_t       cr_q;
  sample_t       cb_q;
  sample_t       luma_q [LANES];
  chroma_terms_t terms;
  pixel_t        pixel_next [LANES];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Hold the format register
  always_ff @(posedge clk) begin
    if (rst) begin
      chroma_format <= FMT_411;
    end else if (cfg_valid && cfg_ready) begin
      chroma_format <= cfg_data;
    end
  end

  // Capture the input beat
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cr_q      <= chroma_red;
      cb_q      <= chroma_blue;
      luma_q[0] <= luma_0;
      luma_q[1] <= luma_1;
      luma_q[2] <= luma_2;
      luma_q[3] <= luma_3;
    end
  end

  // Shared chroma products
  ycq_chroma_terms u_terms (
    .chroma_red    (cr_q),
    .chroma_blue   (cb_q),
    .chroma_format (chroma_format),
    .terms         (terms)
  );

  // One conversion lane per pixel
  for (genvar k = 0; k < LANES; k++) begin : g_lane
    ycq_pixel_lane u_lane (
      .luma          (luma_q[k]),
      .terms         (terms),
      .chroma_format (chroma_format),
      .pixel         (pixel_next[k])
    );
  end

  // Register the result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      pixel_0 <= pixel_next[0];
      pixel_1 <= pixel_next[1];
      pixel_2 <= pixel_next[2];
      pixel_3 <= pixel_next[3];
    end
  end

endmodule
